>>> rtl/core/rlcsq_pkg.sv
`default_nettype none
package rlcsq_pkg;

	localparam int DEF_QUEUE_DEPTH = 64;
	localparam int DEF_SEQ_BITS    = 10;
	localparam int MAX_SEGMENTS    = 64;
	localparam int SEG_CNT_W       = $clog2(MAX_SEGMENTS + 1);

	localparam int OP_W       = 2;
	localparam int TAG_W      = 16;
	localparam int LEN_W      = 16;
	localparam int OCC_W      = 24;
	localparam int HDR_W      = 4;
	localparam int FI_W       = 2;
	localparam int PDU_SEQ_W  = 10;
	localparam int SEQ_MAX_W  = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam int ENTRY_W    = TAG_W + 2 * LEN_W;

	localparam logic [HDR_W-1:0] HEADER_RESET = 4'd2;

	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER      = 1'd1;

	typedef enum logic [OP_W-1:0] {
		OP_ENQUEUE = 2'd0,
		OP_BUILD   = 2'd1,
		OP_REMOVE  = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEG,
		ST_REMOVE
	} state_t;

	typedef struct packed {
		logic enq;
		logic build_start;
		logic build_empty;
		logic seg;
		logic rm_read;
		logic rm_apply;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic build_none;
		logic count_zero;
		logic seg_final;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/core/rlcsq_ctrl.sv
`default_nettype none
module rlcsq_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rlcsq_pkg::OP_W-1:0] operation,
	input  wire rlcsq_pkg::sts_t           sts,
	output logic                           busy,
	output rlcsq_pkg::cmd_t                cmd
);
	import rlcsq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (op_t'(operation))
						OP_ENQUEUE: cmd.enq = 1'b1;
						OP_BUILD: begin
							if (sts.build_none) begin
								cmd.build_empty = 1'b1;
							end else begin
								cmd.build_start = 1'b1;
								state_d         = ST_SEG;
							end
						end
						OP_REMOVE: begin
							if (!sts.count_zero) begin
								cmd.rm_read = 1'b1;
								state_d     = ST_REMOVE;
							end
						end
						OP_CLEAR: cmd.clr = 1'b1;
					endcase
				end
			end
			ST_SEG: begin
				cmd.seg = 1'b1;
				if (sts.seg_final) begin
					state_d = ST_IDLE;
				end
			end
			ST_REMOVE: begin
				cmd.rm_apply = 1'b1;
				state_d      = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/rlcsq_datapath.sv
`default_nettype none
module rlcsq_datapath #(
	parameter int QUEUE_DEPTH = rlcsq_pkg::DEF_QUEUE_DEPTH,
	parameter int SEQ_BITS    = rlcsq_pkg::DEF_SEQ_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire rlcsq_pkg::cmd_t                  cmd,
	output rlcsq_pkg::sts_t                       sts,
	input  wire logic                             cfg_we,
	input  wire logic [rlcsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rlcsq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [rlcsq_pkg::TAG_W-1:0]      unit_tag,
	input  wire logic [rlcsq_pkg::LEN_W-1:0]      unit_payload_bytes,
	input  wire logic [rlcsq_pkg::LEN_W-1:0]      unit_total_bytes,
	input  wire logic [rlcsq_pkg::LEN_W-1:0]      pdu_request_bytes,
	output logic                                  strobe,
	output logic                                  accepted,
	output logic [rlcsq_pkg::TAG_W-1:0]           segment_tag,
	output logic [rlcsq_pkg::LEN_W-1:0]           segment_bytes,
	output logic                                  pdu_empty,
	output logic [rlcsq_pkg::FI_W-1:0]            framing_info,
	output logic [rlcsq_pkg::PDU_SEQ_W-1:0]       pdu_sequence,
	output logic [rlcsq_pkg::LEN_W-1:0]           pdu_data_bytes,
	output logic                                  last
);
	import rlcsq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	// configuration
	logic [OCC_W-1:0] limit_q;
	logic [HDR_W-1:0] header_q;

	// queue state
	logic [ENTRY_W-1:0]  mem [QUEUE_DEPTH];
	logic [ENTRY_W-1:0]  rd_data_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [OCC_W-1:0]    occ_q;
	logic [LEN_W-1:0]    head_rem_q;
	logic                head_split_q;
	logic [SEQ_BITS-1:0] next_seq_q;

	// build state
	logic [LEN_W-1:0]     space_q;
	logic [LEN_W-1:0]     len_q;
	logic [SEG_CNT_W-1:0] nseg_q;
	logic                 start_frag_q;

	// result registers
	logic                 strobe_q;
	logic                 accepted_q;
	logic [TAG_W-1:0]     tag_q;
	logic [LEN_W-1:0]     bytes_q;
	logic                 empty_q;
	logic [FI_W-1:0]      fi_q;
	logic [PDU_SEQ_W-1:0] seq_q;
	logic [LEN_W-1:0]     data_q;
	logic                 last_q;

	logic [TAG_W-1:0] rd_tag;
	logic [LEN_W-1:0] rd_payload;
	logic [LEN_W-1:0] rd_total;
	assign {rd_tag, rd_payload, rd_total} = rd_data_q;

	// enqueue
	logic [OCC_W:0]  enq_sum;
	logic            enq_ok;
	logic [AW-1:0]   wr_addr;
	logic [CW-1:0]   count_m1;
	logic [AW-1:0]   head_inc;
	logic [AW-1:0]   newest;

	assign enq_sum  = {1'b0, occ_q} + (OCC_W + 1)'(unit_total_bytes);
	assign enq_ok   = (count_q < DEPTH_C) &&
		((limit_q == '0) ? !enq_sum[OCC_W] : (enq_sum < {1'b0, limit_q}));
	assign wr_addr  = wrap_add(head_q, count_q[AW-1:0]);
	assign count_m1 = count_q - CW'(1);
	assign head_inc = wrap_add(head_q, AW'(1));
	assign newest   = wrap_add(head_q, count_m1[AW-1:0]);

	// build
	logic [LEN_W-1:0]     req_space;
	logic [LEN_W-1:0]     ulen;
	logic                 fits;
	logic [LEN_W-1:0]     seg_len;
	logic [LEN_W-1:0]     len_new;
	logic [LEN_W-1:0]     space_new;
	logic                 seg_final;
	logic                 pdu_nonzero;
	logic [SEQ_MAX_W-1:0] seq_ext;

	assign req_space   = (pdu_request_bytes > LEN_W'(header_q)) ?
		pdu_request_bytes - LEN_W'(header_q) : '0;
	assign ulen        = head_split_q ? head_rem_q : rd_payload;
	assign fits        = (space_q >= ulen);
	assign seg_len     = fits ? ulen : space_q;
	assign len_new     = len_q + seg_len;
	assign space_new   = space_q - ulen;
	assign seg_final   = !fits || (count_q == CW'(1)) || (space_new == '0) ||
		(nseg_q == SEG_CNT_W'(MAX_SEGMENTS - 1));
	assign pdu_nonzero = (len_new != '0);
	assign seq_ext     = SEQ_MAX_W'(next_seq_q);

	assign sts.build_none = (count_q == '0) || (req_space == '0);
	assign sts.count_zero = (count_q == '0);
	assign sts.seg_final  = seg_final;

	// occupancy after a pop
	logic [OCC_W-1:0] occ_less;
	assign occ_less = (occ_q > OCC_W'(rd_total)) ? occ_q - OCC_W'(rd_total) : '0;

	// memory
	logic [AW-1:0] rd_addr;
	always_comb begin
		priority if (cmd.rm_read) begin
			rd_addr = newest;
		end else if (cmd.seg) begin
			rd_addr = head_inc;
		end else begin
			rd_addr = head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq && enq_ok) begin
			mem[wr_addr] <= {unit_tag, unit_payload_bytes, unit_total_bytes};
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= '0;
			header_q <= HEADER_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_HEADER) begin
				header_q <= cfg_data[HDR_W-1:0];
			end else begin
				limit_q <= cfg_data[OCC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			count_q      <= '0;
			occ_q        <= '0;
			head_rem_q   <= '0;
			head_split_q <= 1'b0;
			next_seq_q   <= '0;
			space_q      <= '0;
			len_q        <= '0;
			nseg_q       <= '0;
			start_frag_q <= 1'b0;
		end else begin
			if (cmd.enq && enq_ok) begin
				count_q <= count_q + CW'(1);
				occ_q   <= enq_sum[OCC_W-1:0];
			end
			if (cmd.build_start) begin
				space_q      <= req_space;
				len_q        <= '0;
				nseg_q       <= '0;
				start_frag_q <= head_split_q;
			end
			if (cmd.seg) begin
				space_q <= fits ? space_new : '0;
				len_q   <= len_new;
				nseg_q  <= nseg_q + SEG_CNT_W'(1);
				if (fits) begin
					occ_q        <= occ_less;
					head_q       <= head_inc;
					count_q      <= count_m1;
					head_split_q <= 1'b0;
					head_rem_q   <= '0;
				end else begin
					head_rem_q   <= ulen - space_q;
					head_split_q <= 1'b1;
				end
				if (seg_final && pdu_nonzero) begin
					next_seq_q <= next_seq_q + SEQ_BITS'(1);
				end
			end
			if (cmd.rm_apply) begin
				occ_q   <= occ_less;
				count_q <= count_m1;
				if (count_q == CW'(1)) begin
					head_split_q <= 1'b0;
					head_rem_q   <= '0;
				end
			end
			if (cmd.clr) begin
				head_q       <= '0;
				count_q      <= '0;
				occ_q        <= '0;
				head_split_q <= 1'b0;
				head_rem_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.enq || cmd.build_empty || cmd.seg;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq || cmd.build_empty) begin
			accepted_q <= cmd.enq && enq_ok;
			tag_q      <= '0;
			bytes_q    <= '0;
			empty_q    <= cmd.build_empty;
			fi_q       <= '0;
			seq_q      <= '0;
			data_q     <= '0;
			last_q     <= 1'b1;
		end else if (cmd.seg) begin
			accepted_q <= 1'b0;
			tag_q      <= rd_tag;
			bytes_q    <= seg_len;
			empty_q    <= seg_final && !pdu_nonzero;
			fi_q       <= (seg_final && pdu_nonzero) ? {start_frag_q, !fits} : '0;
			seq_q      <= (seg_final && pdu_nonzero) ? seq_ext[PDU_SEQ_W-1:0] : '0;
			data_q     <= seg_final ? len_new : '0;
			last_q     <= seg_final;
		end
	end

	assign strobe         = strobe_q;
	assign accepted       = accepted_q;
	assign segment_tag    = tag_q;
	assign segment_bytes  = bytes_q;
	assign pdu_empty      = empty_q;
	assign framing_info   = fi_q;
	assign pdu_sequence   = seq_q;
	assign pdu_data_bytes = data_q;
	assign last           = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("unit count above queue depth");

	a_split_needs_unit: assert property (@(posedge clk) disable iff (!arst_n)
		head_split_q |-> (count_q != '0) && (head_rem_q != '0))
		else $error("split head without a unit or remainder");

	a_enq_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.enq || cmd.build_empty) |=> strobe_q && last_q)
		else $error("single-result transaction without final result");

	a_split_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.seg && !fits) |-> seg_final)
		else $error("split segment not marked final");

endmodule
`default_nettype wire

>>> rtl/core/rlc_um_segmentation_queue_core.sv
// unacknowledged-mode transmit queue with pdu segmentation
// input transaction: start is taken at a rising edge with busy low; operation selects
// enqueue, build pdu, remove newest unit or clear. configuration is a plain write port
// (cfg_we, cfg_index, cfg_data): index 0 queue byte limit, index 1 header size.
// results: each is shown for one cycle with strobe high; last marks the final result
// of a transaction. the receiver cannot stall, so results are never held back.
// operations:
//   enqueue  busy stays low, one result in the following cycle
//   clear    busy stays low, no result
//   remove   store read of the newest unit, then update; no result
//   build    a setup step, then one segment per cycle, at most 64 segments; the
//            unit store has a single read port and a registered output, and
//            results come one per cycle after the setup step; a build on an empty
//            queue or with no space left after the header gives its one result
//            in the following cycle
// reset: queue empty, occupancy zero, sequence zero, byte limit 0 (unlimited),
// header size 2. unit store contents stay undefined; there is no clearing pass.
`default_nettype none
module rlc_um_segmentation_queue_core #(
	parameter int QUEUE_DEPTH = rlcsq_pkg::DEF_QUEUE_DEPTH,
	parameter int SEQ_BITS    = rlcsq_pkg::DEF_SEQ_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [rlcsq_pkg::OP_W-1:0]       operation,
	input  wire logic [rlcsq_pkg::TAG_W-1:0]      unit_tag,
	input  wire logic [rlcsq_pkg::LEN_W-1:0]      unit_payload_bytes,
	input  wire logic [rlcsq_pkg::LEN_W-1:0]      unit_total_bytes,
	input  wire logic [rlcsq_pkg::LEN_W-1:0]      pdu_request_bytes,
	input  wire logic                             cfg_we,
	input  wire logic [rlcsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rlcsq_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                  strobe,
	output logic                                  accepted,
	output logic [rlcsq_pkg::TAG_W-1:0]           segment_tag,
	output logic [rlcsq_pkg::LEN_W-1:0]           segment_bytes,
	output logic                                  pdu_empty,
	output logic [rlcsq_pkg::FI_W-1:0]            framing_info,
	output logic [rlcsq_pkg::PDU_SEQ_W-1:0]       pdu_sequence,
	output logic [rlcsq_pkg::LEN_W-1:0]           pdu_data_bytes,
	output logic                                  last
);
	import rlcsq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rlcsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.busy      (busy),
		.cmd       (cmd)
	);

	rlcsq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.SEQ_BITS    (SEQ_BITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.unit_tag           (unit_tag),
		.unit_payload_bytes (unit_payload_bytes),
		.unit_total_bytes   (unit_total_bytes),
		.pdu_request_bytes  (pdu_request_bytes),
		.strobe             (strobe),
		.accepted           (accepted),
		.segment_tag        (segment_tag),
		.segment_bytes      (segment_bytes),
		.pdu_empty          (pdu_empty),
		.framing_info       (framing_info),
		.pdu_sequence       (pdu_sequence),
		.pdu_data_bytes     (pdu_data_bytes),
		.last               (last)
	);

endmodule
`default_nettype wire
